// ===== rtl/core/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants for the SBUS frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h0F;
    localparam logic [7:0] FLAGS_BYTE  = 8'h00;
    localparam logic [7:0] END_BYTE    = 8'h00;
    localparam logic [3:0] LAST_CHAN   = 4'd15;

    // One classified channel transaction handed from front to back.
    typedef struct packed {
        logic        hdr;   // header byte goes first
        logic        tail;  // flags and end bytes follow
        logic        two;   // two payload bytes instead of one
        logic [15:0] data;  // payload bytes, first byte in [7:0]
    } t_job;

endpackage

// ===== rtl/core/sfe_front.sv =====
// ----------------------------------------------------------------------------
// sfe_front
// Accepts channel values, packs them against the residual bits and
// classifies each transaction into a job for the byte emitter.
// ----------------------------------------------------------------------------
module sfe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [10:0]    i_channel_value,
    output logic           o_push,
    output sfe_pkg::t_job  o_job,
    input  logic           i_full
);

    logic [3:0]  r_chan;
    logic [6:0]  r_bits;
    logic [2:0]  r_cnt;
    logic [3:0]  n_chan;
    logic [6:0]  n_bits;
    logic [2:0]  n_cnt;
    logic [17:0] acc;
    logic        two;
    logic        last;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign acc  = {11'd0, r_bits} | ({7'd0, i_channel_value} << r_cnt);
    assign two  = (r_cnt >= 3'd5);
    assign last = (r_chan == sfe_pkg::LAST_CHAN);

    always_comb begin
        o_job.hdr  = (r_chan == 4'd0);
        o_job.tail = last;
        o_job.two  = two;
        o_job.data = acc[15:0];
        if (last) begin
            n_chan = 4'd0;
            n_bits = 7'd0;
            n_cnt  = 3'd0;
        end else if (two) begin
            n_chan = r_chan + 4'd1;
            n_bits = {5'd0, acc[17:16]};
            n_cnt  = r_cnt - 3'd5;
        end else begin
            n_chan = r_chan + 4'd1;
            n_bits = acc[14:8];
            n_cnt  = r_cnt + 3'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 4'd0;
            r_bits <= 7'd0;
            r_cnt  <= 3'd0;
        end else if (o_push) begin
            r_chan <= n_chan;
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/sfe_queue.sv =====
// ----------------------------------------------------------------------------
// sfe_queue
// Two-entry job queue between the front and the byte emitter.
// ----------------------------------------------------------------------------
module sfe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfe_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sfe_pkg::t_job  o_job
);

    sfe_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== rtl/core/sfe_back.sv =====
// ----------------------------------------------------------------------------
// sfe_back
// Byte emitter: walks each job through header, payload, flags and end
// bytes, one byte per cycle unless the output is stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module sfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  sfe_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_frame_byte,
    output logic           o_frame_end
);

    typedef enum logic [2:0] {
        P_HDR,
        P_B0,
        P_B1,
        P_FLG,
        P_END
    } t_pos;

    t_pos       r_pos;
    t_pos       cur;
    t_pos       n_pos;
    logic       done;
    logic       load;
    logic [7:0] byte_val;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;

    assign cur  = (r_pos == P_HDR && !i_job.hdr) ? P_B0 : r_pos;
    assign load = i_job_valid && (!r_valid || i_ready);
    assign o_pop = load && done;

    always_comb begin
        done     = 1'b0;
        n_pos    = P_HDR;
        byte_val = sfe_pkg::HEADER_BYTE;
        unique case (cur)
            P_HDR: begin
                byte_val = sfe_pkg::HEADER_BYTE;
                n_pos    = P_B0;
            end
            P_B0: begin
                byte_val = i_job.data[7:0];
                if (i_job.two) begin
                    n_pos = P_B1;
                end else if (i_job.tail) begin
                    n_pos = P_FLG;
                end else begin
                    done = 1'b1;
                end
            end
            P_B1: begin
                byte_val = i_job.data[15:8];
                if (i_job.tail) begin
                    n_pos = P_FLG;
                end else begin
                    done = 1'b1;
                end
            end
            P_FLG: begin
                byte_val = sfe_pkg::FLAGS_BYTE;
                n_pos    = P_END;
            end
            P_END: begin
                byte_val = sfe_pkg::END_BYTE;
                done     = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= P_HDR;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos   <= done ? P_HDR : n_pos;
                r_valid <= 1'b1;
                r_byte  <= byte_val;
                r_end   <= (cur == P_END);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_end  = r_end;

endmodule

// ===== rtl/core/sbus_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_encoder_unit
// Streams 16 eleven-bit channel values into 25-byte SBUS frames.
// ----------------------------------------------------------------------------
// A channel transaction is accepted in any cycle the two-entry job queue has
// room; the front packs it LSB-first against the residual bits at once. The
// byte emitter drives one frame byte per cycle while the output is not
// stalled, so a channel costs one to four frame bytes: channel 0 two (header
// and payload), channels 1 to 14 one or two, channel 15 four (payload, flags,
// end).
module sbus_frame_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [10:0] i_channel_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end
);

    sfe_pkg::t_job push_job;
    sfe_pkg::t_job head_job;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;

    sfe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_channel_value (i_channel_value),
        .o_push          (push),
        .o_job           (push_job),
        .i_full          (full)
    );

    sfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    sfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (head_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

endmodule

// ===== rtl/core/sfe_checker.sv =====
// ----------------------------------------------------------------------------
// sfe_port_checker
// Port-level checks for the SBUS frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfe_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_frame_byte,
    input logic        o_frame_end
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_frame_byte) && $stable(o_frame_end))
        else $error("output transaction changed while stalled");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_frame_byte == sfe_pkg::END_BYTE)
        else $error("end byte not zero");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("reset did not clear output and queue");

endmodule

bind sbus_frame_encoder_unit sfe_port_checker u_sfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_frame_byte (o_frame_byte),
    .o_frame_end  (o_frame_end)
);

// ===== test/sfe_checker.sv =====
// ----------------------------------------------------------------------------
// sfe_checker
// Watches both channels of the SBUS frame encoder and checks every byte.
// Each accepted channel transaction is packed LSB-first against a private
// copy of the residual bits and channel count. The bytes it completes are
// queued and compared, field by field, with the bytes the block emits.
// ----------------------------------------------------------------------------
module sfe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [10:0] i_channel_value,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    t_frame_byte frame_q[$];
    logic [3:0]  next_chan;
    logic [6:0]  carry_bits;
    logic [2:0]  carry_cnt;

    task automatic pack_channel(input logic [10:0] value);
        logic [17:0] acc;
        int          nbits;
        if (next_chan == 4'd0) begin
            frame_q.push_back({sfe_pkg::HEADER_BYTE, 1'b0});
        end
        acc   = {11'd0, carry_bits} | ({7'd0, value} << carry_cnt);
        nbits = int'(carry_cnt) + 11;
        while (nbits >= 8) begin
            frame_q.push_back({acc[7:0], 1'b0});
            acc   = acc >> 8;
            nbits = nbits - 8;
        end
        carry_bits = acc[6:0];
        carry_cnt  = nbits[2:0];
        if (next_chan == sfe_pkg::LAST_CHAN) begin
            frame_q.push_back({sfe_pkg::FLAGS_BYTE, 1'b0});
            frame_q.push_back({sfe_pkg::END_BYTE, 1'b1});
            carry_bits = 7'd0;
            carry_cnt  = 3'd0;
            next_chan  = 4'd0;
        end else begin
            next_chan = next_chan + 4'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (!i_rst_n) begin
            frame_q.delete();
            next_chan  = 4'd0;
            carry_bits = 7'd0;
            carry_cnt  = 3'd0;
            o_errors   = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                pack_channel(i_channel_value);
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected transaction, byte %h end %b",
                             $time, i_frame_byte, i_frame_end);
                    o_errors++;
                end else begin
                    want = frame_q.pop_front();
                    if (i_frame_byte !== want.value) begin
                        $display("%0t: frame_byte expected %h actual %h",
                                 $time, want.value, i_frame_byte);
                        o_errors++;
                    end
                    if (i_frame_end !== want.last) begin
                        $display("%0t: frame_end expected %b actual %b",
                                 $time, want.last, i_frame_end);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = frame_q.size();
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the SBUS frame encoder.
// A directed run of 24 corner values comes first, then random channel values
// with random gaps on the input and random stalls on the output, one long
// output hold-off and one input pause until the output has drained.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEMS    = 500;
    localparam int LIMIT    = 200000;
    localparam int HOLD_AT  = 150;
    localparam int HOLD_LEN = 300;
    localparam int DRAIN    = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        tx_valid;
    logic [10:0] tx_value;
    logic        rx_ready;
    logic        dut_ready;
    logic        dut_valid;
    logic [7:0]  dut_byte;
    logic        dut_end;
    int          errors;
    int          pending;
    int          cycle_count = 0;
    int          rx_count    = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;

    logic [10:0] corner_vals [24] = '{
        11'h000, 11'h7FF, 11'h001, 11'h400, 11'h555, 11'h2AA, 11'h7FE, 11'h3FF,
        11'h000, 11'h000, 11'h7FF, 11'h7FF, 11'h0F0, 11'h70F, 11'h123, 11'h7FF,
        11'h7FF, 11'h000, 11'h2AA, 11'h555, 11'h080, 11'h77F, 11'h001, 11'h400
    };

    sbus_frame_encoder_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (tx_valid),
        .o_ready         (dut_ready),
        .i_channel_value (tx_value),
        .o_valid         (dut_valid),
        .i_ready         (rx_ready),
        .o_frame_byte    (dut_byte),
        .o_frame_end     (dut_end)
    );

    sfe_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (tx_valid),
        .i_in_ready      (dut_ready),
        .i_channel_value (tx_value),
        .i_out_valid     (dut_valid),
        .i_out_ready     (rx_ready),
        .i_frame_byte    (dut_byte),
        .i_frame_end     (dut_end),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    always #10 clk = ~clk;

    task automatic send_channel(input logic [10:0] value);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge clk);
            tx_valid <= 1'b0;
        end
        @(negedge clk);
        tx_valid <= 1'b1;
        tx_value <= value;
        @(posedge clk);
        while (!dut_ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        tx_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [10:0] random_channel();
        logic [10:0] bit_sel;
        bit_sel = 11'd1 << $urandom_range(0, 10);
        case ($urandom_range(0, 7))
            0:       return 11'h000;
            1:       return 11'h7FF;
            2:       return bit_sel;
            3:       return ~bit_sel;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    // output side: random stalls, one long hold-off
    initial begin
        int gap;
        rx_ready = 1'b0;
        wait (rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 7);
            if (rx_count == HOLD_AT) gap = HOLD_LEN;
            repeat (gap) begin
                @(negedge clk);
                rx_ready <= 1'b0;
            end
            @(negedge clk);
            rx_ready <= 1'b1;
            @(posedge clk);
            while (!dut_valid) @(posedge clk);
            rx_count++;
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        rst_n    = 1'b0;
        tx_valid = 1'b0;
        tx_value = 11'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_vals[k]) send_channel(corner_vals[k]);
        wait_drained();

        for (int k = 0; k < ITEMS; k++) begin
            if (k == ITEMS / 2) wait_drained();
            send_channel(random_channel());
        end
        wait_drained();

        repeat (DRAIN) @(negedge clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
